[hw/rtl/dhd_pkg.sv]
// shared types and constants of the detection head decode block
// no dependencies, compiled first
package dhd_pkg;

  localparam int CLASS_COUNT = 80;
  localparam int CLS_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  localparam int SCORE_W = 16;
  localparam int COORD_W = 16;
  localparam int INV_W   = 24;
  localparam int PIX_W   = 13;
  localparam int IDX_W   = 9;
  localparam int CFG_W   = 24;
  localparam int CFG_A_W = 3;

  localparam int FRAC_BITS = 23;
  localparam int NUM_W     = COORD_W + 3;
  localparam int PROD_W    = NUM_W + INV_W + 1;
  localparam int EXT_W     = COORD_W + INV_W;
  localparam int LIM_W     = PIX_W + FRAC_BITS;

  typedef enum logic [CFG_A_W-1:0] {
    REG_SCORE_THRESHOLD = 3'd0,
    REG_INVERSE_SCALE   = 3'd1,
    REG_PAD_LEFT        = 3'd2,
    REG_PAD_TOP         = 3'd3,
    REG_IMAGE_WIDTH     = 3'd4,
    REG_IMAGE_HEIGHT    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [SCORE_W-1:0] score_threshold;
    logic [INV_W-1:0]   inverse_scale;
    logic [COORD_W-1:0] pad_left;
    logic [COORD_W-1:0] pad_top;
    logic [PIX_W-1:0]   image_width;
    logic [PIX_W-1:0]   image_height;
  } cfg_t;

  typedef struct packed {
    logic signed [IDX_W-1:0] class_index;
    logic [SCORE_W-1:0]      best_score;
    logic [COORD_W-1:0]      center_x;
    logic [COORD_W-1:0]      center_y;
    logic [COORD_W-1:0]      box_width;
    logic [COORD_W-1:0]      box_height;
  } job_t;

  localparam logic signed [IDX_W-1:0] NO_CLASS = '1;

endpackage

[hw/rtl/dhd_stream_if.sv]
// score input and box output channels of the detection head decode block
// depends on dhd_pkg
interface dhd_in_if;
  logic                        valid;
  logic                        ready;
  logic [dhd_pkg::SCORE_W-1:0] class_score;
  logic                        last_class;
  logic [dhd_pkg::COORD_W-1:0] center_x;
  logic [dhd_pkg::COORD_W-1:0] center_y;
  logic [dhd_pkg::COORD_W-1:0] box_width;
  logic [dhd_pkg::COORD_W-1:0] box_height;

  modport source(output valid, class_score, last_class, center_x, center_y, box_width,
                 box_height, input ready);
  modport sink(input valid, class_score, last_class, center_x, center_y, box_width,
               box_height, output ready);
endinterface

interface dhd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dhd_pkg::IDX_W-1:0]   class_index;
  logic [dhd_pkg::SCORE_W-1:0]        best_score;
  logic [dhd_pkg::PIX_W-1:0]          left_px;
  logic [dhd_pkg::PIX_W-1:0]          top_px;
  logic [dhd_pkg::PIX_W-1:0]          width_px;
  logic [dhd_pkg::PIX_W-1:0]          height_px;

  modport source(output valid, class_index, best_score, left_px, top_px, width_px,
                 height_px, input ready);
  modport sink(input valid, class_index, best_score, left_px, top_px, width_px,
               height_px, output ready);
endinterface

[hw/rtl/detection_head_decode.sv]
// detection head decode top level: config registers, front end, queue, back end
// depends on dhd_pkg, dhd_stream_if, dhd_front, dhd_queue, dhd_back
//
// usage
//   in_i carries one class score per request, class after class for an anchor;
//   last_class marks the anchor's final score, and the box fields are read
//   from that request only
//   out_o carries one box per anchor whose best score meets score_threshold,
//   mapped to original image pixels and clamped to the image
//   config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the next
//   edge and are expected only while no anchor is in flight
// throughput: one score request per cycle; in_i.ready drops only while the
//   four-entry job queue is full
// path: with the queue empty a box is written into the queue, then passes the back end
//   stages in order (queue read with offset, multiply, corner clamp, size clamp) to out_o
// reset: running maximum, class and counter clear, the queue and pipeline
//   empty, and the registers take their default values
// stall: when out_o.ready is low with a box waiting the back end pipeline holds;
//   jobs collect in the queue, and score requests still flow until it fills
module detection_head_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dhd_in_if.sink                      in_i,
  dhd_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [dhd_pkg::CFG_A_W-1:0] cfg_idx_i,
  input  logic [dhd_pkg::CFG_W-1:0]   cfg_data_i
);
  import dhd_pkg::*;

  cfg_t cfg_q;
  logic push, full, pop, empty;
  job_t push_job, pop_job;

  // register file, writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_threshold <= SCORE_W'(22938);
      cfg_q.inverse_scale   <= INV_W'(65536);
      cfg_q.pad_left        <= '0;
      cfg_q.pad_top         <= '0;
      cfg_q.image_width     <= PIX_W'(640);
      cfg_q.image_height    <= PIX_W'(640);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCORE_THRESHOLD: cfg_q.score_threshold <= cfg_data_i[SCORE_W-1:0];
        REG_INVERSE_SCALE:   cfg_q.inverse_scale   <= cfg_data_i[INV_W-1:0];
        REG_PAD_LEFT:        cfg_q.pad_left        <= cfg_data_i[COORD_W-1:0];
        REG_PAD_TOP:         cfg_q.pad_top         <= cfg_data_i[COORD_W-1:0];
        REG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data_i[PIX_W-1:0];
        REG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // front end decides per anchor whether a box is produced
  dhd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .threshold_i (cfg_q.score_threshold),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // decouples score intake from output back pressure
  dhd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  // coordinate mapping and clamping
  dhd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .job_i   (pop_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[hw/rtl/dhd_front.sv]
// front end: running class maximum per anchor, threshold test, job push
// depends on dhd_pkg and dhd_in_if
module dhd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dhd_in_if.sink                 in_i,
  input  logic [dhd_pkg::SCORE_W-1:0] threshold_i,
  input  logic                   full_i,
  output logic                   push_o,
  output dhd_pkg::job_t          job_o
);
  import dhd_pkg::*;

  logic [SCORE_W-1:0]      max_q, max_d;
  logic signed [IDX_W-1:0] cls_q, cls_d;
  logic [CLS_W-1:0]        cnt_q, cnt_d;
  logic                    take;
  logic                    better;
  logic [SCORE_W-1:0]      best;
  logic signed [IDX_W-1:0] best_cls;

  assign in_i.ready = !full_i;
  assign take       = in_i.valid && !full_i;
  assign better     = in_i.class_score > max_q;
  assign best       = better ? in_i.class_score : max_q;
  assign best_cls   = better ? $signed(IDX_W'(cnt_q)) : cls_q;

  always_comb begin
    max_d = max_q;
    cls_d = cls_q;
    cnt_d = cnt_q;
    if (take) begin
      if (in_i.last_class) begin
        max_d = '0;
        cls_d = NO_CLASS;
        cnt_d = '0;
      end else begin
        max_d = best;
        cls_d = best_cls;
        if (cnt_q < CLS_W'(CLASS_COUNT - 1)) cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      cls_q <= NO_CLASS;
      cnt_q <= '0;
    end else begin
      max_q <= max_d;
      cls_q <= cls_d;
      cnt_q <= cnt_d;
    end
  end

  assign push_o = take && in_i.last_class && (best >= threshold_i);

  always_comb begin
    job_o.class_index = best_cls;
    job_o.best_score  = best;
    job_o.center_x    = in_i.center_x;
    job_o.center_y    = in_i.center_y;
    job_o.box_width   = in_i.box_width;
    job_o.box_height  = in_i.box_height;
  end

endmodule

[hw/rtl/dhd_queue.sv]
// short job queue between the front end and the box mapping pipeline
// depends on dhd_pkg
module dhd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dhd_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output dhd_pkg::job_t pop_data_o,
  output logic          empty_o
);
  import dhd_pkg::*;

  job_t            mem_q [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_q, rd_q;
  logic [QA_W:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o     = cnt_q == (QA_W+1)'(QUEUE_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop) rd_q <= (rd_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

[hw/rtl/dhd_back.sv]
// back end: maps a box to image pixels in a four stage pipeline
// depends on dhd_pkg and dhd_out_if
module dhd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dhd_pkg::cfg_t cfg_i,
  input  logic          empty_i,
  input  dhd_pkg::job_t job_i,
  output logic          pop_o,
  dhd_out_if.source     out_o
);
  import dhd_pkg::*;

  localparam logic [EXT_W:0] ONE_PX = {{(EXT_W-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic signed [IDX_W-1:0] class_index;
    logic [SCORE_W-1:0]      best_score;
  } meta_t;

  logic adv;
  logic v1_q, v2_q, v3_q, ov_q;
  meta_t m1_q, m2_q, m3_q, om_q;

  logic signed [NUM_W-1:0]  num_q  [2];
  logic [COORD_W-1:0]       size_q [2];
  logic signed [PROD_W-1:0] pos_q  [2];
  logic [EXT_W-1:0]         ext_q  [2];
  logic [LIM_W-1:0]         posc_q [2];
  logic [LIM_W-1:0]         room_q [2];
  logic [EXT_W:0]           ext2_q [2];
  logic [PIX_W-1:0]         corner_q [2];
  logic [PIX_W-1:0]         span_q   [2];

  logic signed [NUM_W-1:0]  num_d  [2];
  logic signed [PROD_W-1:0] pos_d  [2];
  logic [EXT_W-1:0]         ext_d  [2];
  logic [LIM_W-1:0]         posc_d [2];
  logic [LIM_W-1:0]         room_d [2];
  logic [LIM_W-1:0]         span_d [2];

  logic [COORD_W-1:0] cen   [2];
  logic [COORD_W-1:0] siz   [2];
  logic [COORD_W-1:0] pad   [2];
  logic [PIX_W-1:0]   limit [2];

  // whole pipeline moves together, held only by a stalled output
  assign adv   = !ov_q || out_o.ready;
  assign pop_o = adv && !empty_i;

  assign cen[0]   = job_i.center_x;
  assign cen[1]   = job_i.center_y;
  assign siz[0]   = job_i.box_width;
  assign siz[1]   = job_i.box_height;
  assign pad[0]   = cfg_i.pad_left;
  assign pad[1]   = cfg_i.pad_top;
  assign limit[0] = cfg_i.image_width;
  assign limit[1] = cfg_i.image_height;

  always_comb begin
    logic [LIM_W-1:0] lim;
    logic [EXT_W:0]   ext_m;
    for (int a = 0; a < 2; a++) begin
      // doubled corner offset, in 1/128 px
      num_d[a] = $signed({2'b00, cen[a], 1'b0}) - $signed({2'b00, pad[a], 1'b0})
               - $signed({3'b000, siz[a]});
      pos_d[a] = num_q[a] * $signed({1'b0, cfg_i.inverse_scale});
      ext_d[a] = size_q[a] * cfg_i.inverse_scale;

      lim = {limit[a], {FRAC_BITS{1'b0}}};
      if (pos_q[a][PROD_W-1]) posc_d[a] = '0;
      else if (pos_q[a][PROD_W-2:0] > {{(PROD_W-1-LIM_W){1'b0}}, lim}) posc_d[a] = lim;
      else posc_d[a] = pos_q[a][LIM_W-1:0];
      room_d[a] = lim - posc_d[a];

      // size clamp; no room at the edge gives one pixel
      ext_m = (ext2_q[a] < ONE_PX) ? ONE_PX : ext2_q[a];
      if (room_q[a][LIM_W-1:FRAC_BITS] == '0) span_d[a] = ONE_PX[LIM_W-1:0];
      else if (ext_m > {{(EXT_W+1-LIM_W){1'b0}}, room_q[a]}) span_d[a] = room_q[a];
      else span_d[a] = ext_m[LIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= !empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q <= '{class_index: job_i.class_index, best_score: job_i.best_score};
      m2_q <= m1_q;
      m3_q <= m2_q;
      om_q <= m3_q;
      for (int a = 0; a < 2; a++) begin
        num_q[a]    <= num_d[a];
        size_q[a]   <= siz[a];
        pos_q[a]    <= pos_d[a];
        ext_q[a]    <= ext_d[a];
        posc_q[a]   <= posc_d[a];
        room_q[a]   <= room_d[a];
        ext2_q[a]   <= {ext_q[a], 1'b0};
        corner_q[a] <= posc_q[a][LIM_W-1:FRAC_BITS];
        span_q[a]   <= span_d[a][LIM_W-1:FRAC_BITS];
      end
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.class_index = om_q.class_index;
  assign out_o.best_score  = om_q.best_score;
  assign out_o.left_px     = corner_q[0];
  assign out_o.top_px      = corner_q[1];
  assign out_o.width_px    = span_q[0];
  assign out_o.height_px   = span_q[1];

endmodule

[hw/rtl/dhd_checker.sv]
// port level checks of the detection head decode block, bound to the top level
// depends on dhd_pkg and detection_head_decode
module dhd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic signed [dhd_pkg::IDX_W-1:0] class_index_i,
  input logic [dhd_pkg::SCORE_W-1:0] best_score_i,
  input logic [dhd_pkg::PIX_W-1:0]   width_px_i,
  input logic [dhd_pkg::PIX_W-1:0]   height_px_i
);
  import dhd_pkg::*;

  // a box always has at least one pixel in each direction
  a_min_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (width_px_i != '0) && (height_px_i != '0))
    else $error("box size of zero");

  // a real class implies a nonzero best score, and no class implies zero
  a_class_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((class_index_i == NO_CLASS) == (best_score_i == '0)))
    else $error("class index and best score disagree");

  // class index is either no class or a counter value
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!class_index_i[IDX_W-1] || class_index_i == NO_CLASS))
    else $error("class index out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(class_index_i)
      && $stable(best_score_i))
    else $error("stalled box request dropped or changed");

endmodule

bind detection_head_decode dhd_checker u_dhd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .class_index_i (out_o.class_index),
  .best_score_i  (out_o.best_score),
  .width_px_i    (out_o.width_px),
  .height_px_i   (out_o.height_px)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// testbench for detection_head_decode: score requests in, mapped boxes out, checked
// against a local predictor; depends on dhd_pkg, dhd_stream_if and the block's rtl
module tb_top;
  import dhd_pkg::*;

  localparam int     NUM_PHASES   = 10;
  localparam int     PHASE_ITEMS  = 165;
  localparam int     SETTLE_CYCLES = 64;   // queue plus back end pipeline, with margin
  localparam int     DRAIN_LIMIT  = 4000;
  localparam int     BOX_FRAC     = 23;    // box math runs in 2^-23 pixel units
  localparam longint ONE_PIXEL    = longint'(1) << BOX_FRAC;

  // one score request on the input channel
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               last;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
  } score_item_t;

  // one box request on the output channel
  typedef struct packed {
    logic signed [IDX_W-1:0] class_index;
    logic [SCORE_W-1:0]      best_score;
    logic [PIX_W-1:0]        left_px;
    logic [PIX_W-1:0]        top_px;
    logic [PIX_W-1:0]        width_px;
    logic [PIX_W-1:0]        height_px;
  } box_t;

  // how a directed row is checked: by the predictor, against a typed box, or no box
  typedef enum logic [1:0] {CHK_MODEL, CHK_BOX, CHK_NO_BOX} box_check_e;
  typedef enum logic {ROW_SCORE, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {PH_LOW, PH_HIGH, PH_TYPICAL, PH_MIXED} phase_mode_e;

  typedef struct packed {
    row_kind_e          kind;
    reg_idx_e           reg_idx;
    logic [CFG_W-1:0]   reg_value;
    score_item_t        item;
    box_check_e         check;
    box_t               box;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_A_W-1:0]  cfg_idx;
  logic [CFG_W-1:0]    cfg_data;

  dhd_in_if  in_if ();
  dhd_out_if out_if ();

  detection_head_decode u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // register copy as the block should hold it, starting from the reset defaults
  cfg_t shadow_cfg = '{score_threshold: 16'd22938, inverse_scale: 24'd65536,
                       pad_left: '0, pad_top: '0,
                       image_width: 13'd640, image_height: 13'd640};

  // per-anchor accumulator state of the predictor
  logic [SCORE_W-1:0]      top_score = '0;
  logic signed [IDX_W-1:0] top_class = NO_CLASS;
  int                      class_pos = 0;

  box_t      pending_boxes[$];
  int        fail_count  = 0;
  bit        source_gaps = 1'b1;
  bit        sink_stalls = 1'b1;
  int        sink_hold   = 0;
  stim_row_t stim_rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous fixed limit, far above the slowest legal run
  initial begin
    #(20_000_000);
    $display("Verification failed");
    $finish;
  end

  // maps one axis to original image pixels: corner and extent, clamped to the image
  function automatic void project_axis(input logic [COORD_W-1:0] center, size, pad,
                                       input logic [PIX_W-1:0] limit,
                                       output logic [PIX_W-1:0] corner, extent);
    longint c, s, p, inv, num, pos, lim, ext, room;
    c   = center;
    s   = size;
    p   = pad;
    inv = longint'(shadow_cfg.inverse_scale);
    // doubled coordinates keep the half-size subtraction exact
    num = 2 * c - 2 * p - s;
    pos = num * inv;
    lim = longint'(limit) * ONE_PIXEL;
    ext = s * inv * 2;
    if (pos < 0) pos = 0;
    if (pos > lim) pos = lim;
    room = lim - pos;
    // no room left at the edge: extent is forced to one pixel
    if (room < ONE_PIXEL) begin
      ext = ONE_PIXEL;
    end else begin
      if (ext < ONE_PIXEL) ext = ONE_PIXEL;
      if (ext > room) ext = room;
    end
    corner = PIX_W'(pos >>> BOX_FRAC);
    extent = PIX_W'(ext >>> BOX_FRAC);
  endfunction

  // folds one accepted score into the running maximum; returns 1 when a box is due
  function automatic bit accumulate_score(input score_item_t it, output box_t box);
    bit emits;
    emits = 1'b0;
    box   = '0;
    // strict compare: ties keep the earlier class
    if (it.score > top_score) begin
      top_score = it.score;
      top_class = IDX_W'(class_pos);
    end
    // counter saturates, extra classes compete under the last index
    if (class_pos < CLASS_COUNT - 1) class_pos++;
    if (it.last) begin
      if (top_score >= shadow_cfg.score_threshold) begin
        emits           = 1'b1;
        box.class_index = top_class;
        box.best_score  = top_score;
        project_axis(it.center_x, it.box_width, shadow_cfg.pad_left,
                     shadow_cfg.image_width, box.left_px, box.width_px);
        project_axis(it.center_y, it.box_height, shadow_cfg.pad_top,
                     shadow_cfg.image_height, box.top_px, box.height_px);
      end
      top_score = '0;
      top_class = NO_CLASS;
      class_pos = 0;
    end
    return emits;
  endfunction

  function automatic box_t boxv(input logic signed [IDX_W-1:0] cls,
                                input logic [SCORE_W-1:0] score,
                                input int l, t, w, h);
    box_t b;
    b.class_index = cls;
    b.best_score  = score;
    b.left_px     = PIX_W'(l);
    b.top_px      = PIX_W'(t);
    b.width_px    = PIX_W'(w);
    b.height_px   = PIX_W'(h);
    return b;
  endfunction

  function automatic stim_row_t score_row(input int score, input bit last,
                                          input int cx, cy, bw, bh,
                                          input box_check_e check, input box_t box);
    stim_row_t r;
    r                 = '0;
    r.kind            = ROW_SCORE;
    r.item.score      = SCORE_W'(score);
    r.item.last       = last;
    r.item.center_x   = COORD_W'(cx);
    r.item.center_y   = COORD_W'(cy);
    r.item.box_width  = COORD_W'(bw);
    r.item.box_height = COORD_W'(bh);
    r.check           = check;
    r.box             = box;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input reg_idx_e idx, input int unsigned value);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_REG;
    r.reg_idx   = idx;
    r.reg_value = CFG_W'(value);
    return r;
  endfunction

  // appends one row to the directed table
  function automatic void add_row(input stim_row_t r);
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  // mostly the values that matter for the compare: zero, full scale, at and below threshold
  function automatic logic [SCORE_W-1:0] draw_score(input logic [SCORE_W-1:0] prev);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return shadow_cfg.score_threshold;
      3: return shadow_cfg.score_threshold - 1'b1;
      4: return prev;
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_extreme(input int unsigned lo, hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // one register write; the enable drops for a cycle before the next one
  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCORE_THRESHOLD: shadow_cfg.score_threshold = SCORE_W'(value);
      REG_INVERSE_SCALE:   shadow_cfg.inverse_scale   = INV_W'(value);
      REG_PAD_LEFT:        shadow_cfg.pad_left        = COORD_W'(value);
      REG_PAD_TOP:         shadow_cfg.pad_top         = COORD_W'(value);
      REG_IMAGE_WIDTH:     shadow_cfg.image_width     = PIX_W'(value);
      REG_IMAGE_HEIGHT:    shadow_cfg.image_height    = PIX_W'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // holds the input quiet until every box has come back, then lets anchors without
  // a box clear the queue and pipeline; a box that never shows is a failure
  task automatic wait_drain();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (pending_boxes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_boxes.size() != 0) begin
      if (fail_count < 10)
        $display("%0d expected boxes never arrived", pending_boxes.size());
      fail_count += pending_boxes.size();
      pending_boxes.delete();
    end
  endtask

  // drives one score request, waits for its handshake, then books the expected box
  task automatic send_score(input score_item_t it, input box_check_e check,
                            input box_t typed_box);
    int   gap;
    bit   emits;
    box_t predicted;
    gap = (source_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.class_score <= it.score;
    in_if.last_class  <= it.last;
    in_if.center_x    <= it.center_x;
    in_if.center_y    <= it.center_y;
    in_if.box_width   <= it.box_width;
    in_if.box_height  <= it.box_height;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    // accepted at this edge; the predictor always runs so its state stays in step
    emits = accumulate_score(it, predicted);
    case (check)
      CHK_MODEL: if (emits) pending_boxes.insert(pending_boxes.size(), predicted);
      CHK_BOX:   pending_boxes.insert(pending_boxes.size(), typed_box);
      default:   ;
    endcase
  endtask

  task automatic program_phase(input phase_mode_e mode);
    cfg_t c;
    case (mode)
      PH_LOW: begin
        c = '{score_threshold: '0, inverse_scale: 24'd1, pad_left: '0, pad_top: '0,
              image_width: 13'd1, image_height: 13'd1};
      end
      PH_HIGH: begin
        c = '{score_threshold: '1, inverse_scale: '1, pad_left: 16'd40960,
              pad_top: 16'd40960, image_width: 13'd4096, image_height: 13'd4096};
      end
      PH_TYPICAL: begin
        // near-unity scale and modest padding, so most boxes land inside the image
        c.score_threshold = SCORE_W'($urandom_range(0, 45000));
        c.inverse_scale   = INV_W'($urandom_range(32768, 262144));
        c.pad_left        = COORD_W'($urandom_range(0, 6400));
        c.pad_top         = COORD_W'($urandom_range(0, 6400));
        c.image_width     = PIX_W'($urandom_range(64, 4096));
        c.image_height    = PIX_W'($urandom_range(64, 4096));
      end
      default: begin
        c.score_threshold = SCORE_W'(pick_extreme(0, 65535));
        c.inverse_scale   = INV_W'(pick_extreme(1, 16777215));
        c.pad_left        = COORD_W'(pick_extreme(0, 40960));
        c.pad_top         = COORD_W'(pick_extreme(0, 40960));
        c.image_width     = PIX_W'(pick_extreme(1, 4096));
        c.image_height    = PIX_W'(pick_extreme(1, 4096));
      end
    endcase
    write_reg(REG_SCORE_THRESHOLD, c.score_threshold);
    write_reg(REG_INVERSE_SCALE, c.inverse_scale);
    write_reg(REG_PAD_LEFT, c.pad_left);
    write_reg(REG_PAD_TOP, c.pad_top);
    write_reg(REG_IMAGE_WIDTH, c.image_width);
    write_reg(REG_IMAGE_HEIGHT, c.image_height);
  endtask

  // whole anchors with random scores; lengths are mostly short, a few run past
  // the class count so the counter saturates
  task automatic run_anchors(input int item_budget);
    int                 sent, len, pick;
    score_item_t        it;
    logic [SCORE_W-1:0] prev;
    sent = 0;
    prev = '0;
    while (sent < item_budget) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)      len = $urandom_range(1, 6);
      else if (pick < 19) len = $urandom_range(7, 30);
      else                len = $urandom_range(CLASS_COUNT - 5, CLASS_COUNT + 10);
      for (int k = 0; k < len; k++) begin
        it.score      = draw_score(prev);
        it.last       = (k == len - 1);
        it.center_x   = COORD_W'($urandom);
        it.center_y   = COORD_W'($urandom);
        it.box_width  = COORD_W'($urandom);
        it.box_height = COORD_W'($urandom);
        prev = it.score;
        send_score(it, CHK_MODEL, '0);
      end
      sent += len;
    end
  endtask

  // output side backpressure: the sink drops ready in random bursts
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold    <= sink_hold - 1;
      out_if.ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      sink_hold    <= $urandom_range(0, 8);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // box checker: every accepted box request against the oldest expectation
  always @(posedge clk) begin
    box_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.class_index = out_if.class_index;
      got.best_score  = out_if.best_score;
      got.left_px     = out_if.left_px;
      got.top_px      = out_if.top_px;
      got.width_px    = out_if.width_px;
      got.height_px   = out_if.height_px;
      if (pending_boxes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected box: class %0d score %0d at %0d,%0d size %0dx%0d",
                   got.class_index, got.best_score, got.left_px, got.top_px,
                   got.width_px, got.height_px);
      end else begin
        want = pending_boxes.pop_front();
        if (got.class_index !== want.class_index || got.best_score !== want.best_score ||
            got.left_px !== want.left_px || got.top_px !== want.top_px ||
            got.width_px !== want.width_px || got.height_px !== want.height_px) begin
          fail_count++;
          if (fail_count <= 10)
            $display("box mismatch: expected class %0d score %0d at %0d,%0d size %0dx%0d, %s",
                     want.class_index, want.best_score, want.left_px, want.top_px,
                     want.width_px, want.height_px,
                     $sformatf("got class %0d score %0d at %0d,%0d size %0dx%0d",
                               got.class_index, got.best_score, got.left_px,
                               got.top_px, got.width_px, got.height_px));
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    // every block input known from time zero
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    in_if.valid        = 1'b0;
    in_if.class_score  = '0;
    in_if.last_class   = 1'b0;
    in_if.center_x     = '0;
    in_if.center_y     = '0;
    in_if.box_width    = '0;
    in_if.box_height   = '0;
    out_if.ready       = 1'b0;

    // directed rows, reset defaults: threshold 22938, unit scale, no padding, 640x640
    // single-score anchor, box 100,100 size 20 maps to corner 90
    add_row(score_row(65535, 1, 6400, 6400, 1280, 1280, CHK_BOX,
                      boxv(0, 65535, 90, 90, 20, 20)));
    // all-zero anchor and one just under threshold: nothing comes out
    add_row(score_row(0, 1, 0, 0, 0, 0, CHK_NO_BOX, '0));
    add_row(score_row(22937, 1, 0, 0, 0, 0, CHK_NO_BOX, '0));
    // score equal to threshold; box off the left clamps to 0, zero height gives 1
    add_row(score_row(22938, 1, 0, 0, 1280, 0, CHK_BOX,
                      boxv(0, 22938, 0, 0, 20, 1)));
    // tie on every class keeps the first one
    add_row(score_row(30000, 0, 0, 0, 0, 0, CHK_NO_BOX, '0));
    add_row(score_row(30000, 0, 0, 0, 0, 0, CHK_NO_BOX, '0));
    add_row(score_row(30000, 1, 6400, 6400, 1280, 1280, CHK_BOX,
                      boxv(0, 30000, 90, 90, 20, 20)));
    // rising scores pick the last class; box past the right and bottom edges
    add_row(score_row(100, 0, 0, 0, 0, 0, CHK_NO_BOX, '0));
    add_row(score_row(40000, 0, 0, 0, 0, 0, CHK_NO_BOX, '0));
    add_row(score_row(50000, 1, 65535, 65535, 0, 0, CHK_BOX,
                      boxv(2, 50000, 640, 640, 1, 1)));
    // falling scores, full-size box
    add_row(score_row(65535, 0, 777, 888, 999, 111, CHK_MODEL, '0));
    add_row(score_row(1, 1, 12345, 54321, 65535, 40000, CHK_MODEL, '0));
    // zero threshold: even a no-class anchor yields a box
    add_row(reg_row(REG_SCORE_THRESHOLD, 0));
    add_row(score_row(0, 1, 0, 0, 0, 0, CHK_BOX, boxv(NO_CLASS, 0, 0, 0, 1, 1)));
    // largest scale and padding
    add_row(reg_row(REG_INVERSE_SCALE, 16777215));
    add_row(reg_row(REG_PAD_LEFT, 40960));
    add_row(reg_row(REG_PAD_TOP, 40960));
    add_row(score_row(65535, 1, 65535, 0, 65535, 65535, CHK_MODEL, '0));
    add_row(score_row(20000, 1, 40960, 40960, 64, 64, CHK_MODEL, '0));
    // wide image, one-pixel-high image, smallest scale
    add_row(reg_row(REG_IMAGE_WIDTH, 4096));
    add_row(reg_row(REG_IMAGE_HEIGHT, 1));
    add_row(reg_row(REG_INVERSE_SCALE, 1));
    add_row(score_row(65535, 1, 65535, 65535, 65535, 65535, CHK_MODEL, '0));
    add_row(score_row(3, 1, 40961, 40961, 0, 0, CHK_MODEL, '0));
    // zero inverse scale collapses every box to the origin, one pixel
    add_row(reg_row(REG_INVERSE_SCALE, 0));
    add_row(score_row(65535, 1, 65535, 30000, 65535, 1000, CHK_BOX,
                      boxv(0, 65535, 0, 0, 1, 1)));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_REG) begin
        // registers only change with nothing in flight
        wait_drain();
        write_reg(row.reg_idx, row.reg_value);
      end else begin
        send_score(row.item, row.check, row.box);
      end
    end

    // random phases, each with its own register setting; the last ones run
    // without gaps or stalls, and one in the middle does too
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      source_gaps = (p < NUM_PHASES - 2) && (p != 4);
      sink_stalls = source_gaps;
      if (p == 0)          program_phase(PH_LOW);
      else if (p == 1)     program_phase(PH_HIGH);
      else if (p % 2 == 1) program_phase(PH_MIXED);
      else                 program_phase(PH_TYPICAL);
      run_anchors(PHASE_ITEMS);
    end

    wait_drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
